/* src/fsh_pkg.sv */
`timescale 1ns / 1ps

package fsh_pkg;

    localparam int unsigned HASH_W  = 64;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BIOME_W = 16;

    localparam logic [HASH_W-1:0] HASH_BASIS = 64'd14695981039346656037;

    // The FNV prime is 2^40 + 0x1B3, so one round is a shift plus a narrow product.
    localparam int unsigned PRIME_SHIFT = 40;
    localparam logic [8:0]  PRIME_LOW   = 9'h1B3;

    // Round counter inside the multi-round state: values 0 to 2 for rounds 2 to 4 of a block state.
    localparam int unsigned   CNT_W    = 2;
    localparam logic [CNT_W-1:0] CNT_FINAL = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_ROUND = 1'b1
    } state_t;

    typedef enum logic [0:0] {
        MODE_BLOCK = 1'b0,
        MODE_BIOME = 1'b1
    } mode_t;

    typedef struct packed {
        logic load;       // capture the remaining bytes of a new item
        logic sel_input;  // take the round operand from the input ports
        logic biome;      // the input operand is the 16-bit biome value
        logic advance;    // commit one round to the running hash
        logic emit;       // move the folded hash to the output register
    } cmd_t;

    function automatic logic [HASH_W-1:0] fold_round(
        input logic [HASH_W-1:0] h,
        input logic [HASH_W-1:0] v
    );
        logic [HASH_W-1:0] x;
        begin
            x = h ^ v;
            fold_round = (x << PRIME_SHIFT) + (x * HASH_W'(PRIME_LOW));
        end
    endfunction

endpackage

/* src/fsh_ctrl.sv */
`timescale 1ns / 1ps

module fsh_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          mode,
    input  logic          last_element,
    input  logic          out_ready,
    output logic          in_ready,
    output logic          out_valid,
    output fsh_pkg::cmd_t cmd
);
    import fsh_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;
    logic               accept;
    logic               final_round;

    assign out_free    = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == ST_IDLE) && out_free;
    assign accept      = in_valid && in_ready;
    assign final_round = (cnt_reg == CNT_FINAL);
    assign out_valid   = out_valid_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode_t'(mode) == MODE_BLOCK))
                begin
                    state_next = ST_ROUND;
                    cnt_next   = '0;
                    last_next  = last_element;
                end
            end
            ST_ROUND:
            begin
                if (!final_round)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!last_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.sel_input = 1'b1;
                cmd.biome     = (mode_t'(mode) == MODE_BIOME);
                if (accept)
                begin
                    cmd.load    = 1'b1;
                    cmd.advance = 1'b1;
                    cmd.emit    = (mode_t'(mode) == MODE_BIOME) && last_element;
                end
            end
            ST_ROUND:
            begin
                // The last round of a marked item waits for a free output register.
                if (!final_round || !last_reg || out_free)
                begin
                    cmd.advance = 1'b1;
                    cmd.emit    = final_round && last_reg;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result emitted over an untaken result");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("input ready while rounds are in progress");

    a_round_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && final_round && cmd.advance) |=> (state_reg == ST_IDLE))
        else $error("final round did not return to idle");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (cnt_reg <= CNT_FINAL))
        else $error("round counter out of range");

endmodule

/* src/fsh_datapath.sv */
`timescale 1ns / 1ps

module fsh_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fsh_pkg::cmd_t                cmd,
    input  logic [fsh_pkg::VALUE_W-1:0]  element_value,
    output logic [fsh_pkg::HASH_W-1:0]   hash_value
);
    import fsh_pkg::*;

    localparam int unsigned REST_W = VALUE_W - BYTE_W;

    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [REST_W-1:0] rest_reg, rest_next;
    logic [HASH_W-1:0] out_reg;
    logic [HASH_W-1:0] operand;
    logic [HASH_W-1:0] folded;

    always_comb
    begin
        if (cmd.sel_input)
        begin
            if (cmd.biome)
            begin
                operand = HASH_W'(element_value[BIOME_W-1:0]);
            end
            else
            begin
                operand = HASH_W'(element_value[BYTE_W-1:0]);
            end
        end
        else
        begin
            operand = HASH_W'(rest_reg[BYTE_W-1:0]);
        end
    end

    assign folded = fold_round(hash_reg, operand);

    always_comb
    begin
        hash_next = hash_reg;
        if (cmd.emit)
        begin
            hash_next = HASH_BASIS;
        end
        else if (cmd.advance)
        begin
            hash_next = folded;
        end
    end

    always_comb
    begin
        if (cmd.load)
        begin
            rest_next = element_value[VALUE_W-1:BYTE_W];
        end
        else if (cmd.advance)
        begin
            rest_next = rest_reg >> BYTE_W;
        end
        else
        begin
            rest_next = rest_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= HASH_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        if (cmd.emit)
        begin
            out_reg <= folded;
        end
    end

    assign hash_value = out_reg;

    a_basis_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (hash_reg == HASH_BASIS))
        else $error("running hash not restarted after a result");

    a_out_captured: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_reg == $past(folded)))
        else $error("output register missed the finished hash");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.advance && !cmd.emit) |=> $stable(hash_reg))
        else $error("running hash changed without a round");

endmodule

/* src/fnv1a_section_hasher.sv */
`timescale 1ns / 1ps

// FNV-1a section hasher.
// Input channel (in_valid/in_ready) carries one element per item: element_value,
// mode (0 = block state, 1 = biome) and last_element. Output channel
// (out_valid/out_ready) carries hash_value, one item per section, produced on
// the element marked last.
// A biome item is folded in the accept cycle itself, so biomes stream at one
// item per cycle while in_ready stays high. A block-state item needs four
// XOR-multiply rounds on the one shared round unit: the first in the accept
// cycle, three more after it, while in_ready stays low. The hash of a
// section ending in a biome appears on out_valid the cycle after the accept;
// one ending in a block state appears once its final round is committed.
// The finished hash sits in an output register, and the next section can start
// in the same cycle the receiver takes it. When the receiver stalls with that
// register full, in_ready drops and a marked block state holds its final round
// until the register frees.
// Reset clears the running hash to the offset basis and empties the output.
module fnv1a_section_hasher (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fsh_pkg::VALUE_W-1:0]  element_value,
    input  logic                         mode,
    input  logic                         last_element,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fsh_pkg::HASH_W-1:0]   hash_value
);
    import fsh_pkg::*;

    cmd_t cmd;

    fsh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .mode         (mode),
        .last_element (last_element),
        .out_ready    (out_ready),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .cmd          (cmd)
    );

    fsh_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .element_value (element_value),
        .hash_value    (hash_value)
    );

endmodule
